// ===== hdl/mpvs_pkg.sv =====
// Shared types and constants for the matrix palette vertex skinning block.
// Used by the output queue and the top level; depends on nothing else.
`default_nettype none

package mpvs_pkg;

	localparam int BONE_COUNT_DEF = 256;
	localparam int BONE_WORDS_DEF = 12;

	localparam int DATA_W = 32;
	localparam int BONE_W = 8;
	localparam int WIDX_W = 4;
	localparam int BPV_W  = 3;
	localparam int ATTR_W = 2;
	localparam int PROD_W = 48;
	localparam int SUM_W  = 50;

	localparam logic OP_PALETTE   = 1'b0;
	localparam logic OP_INFLUENCE = 1'b1;

	localparam logic [ATTR_W-1:0] ATTR_POS = 2'd0;
	localparam logic [ATTR_W-1:0] ATTR_NRM = 2'd1;
	localparam logic [ATTR_W-1:0] ATTR_TAN = 2'd2;

	localparam logic [BPV_W-1:0] BPV_RESET = 3'd1;
	localparam logic [BPV_W-1:0] BPV_MIN   = 3'd1;
	localparam logic [BPV_W-1:0] BPV_MAX   = 3'd4;

	localparam logic [DATA_W-1:0] ONE_Q16 = 32'h0001_0000;

	typedef struct packed {
		logic [DATA_W-1:0] ox;
		logic [DATA_W-1:0] oy;
		logic [DATA_W-1:0] oz;
		logic [DATA_W-1:0] ow;
		logic [ATTR_W-1:0] attr;
	} res_t;

	// Clamp a wide signed value to the signed 32-bit range.
	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
		logic hi_ones;
		logic hi_zeros;
		hi_ones  = &v[SUM_W-2:DATA_W-1];
		hi_zeros = ~|v[SUM_W-2:DATA_W-1];
		if (!v[SUM_W-1] && !hi_zeros) begin
			sat32 = 32'sh7FFF_FFFF;
		end else if (v[SUM_W-1] && !hi_ones) begin
			sat32 = 32'sh8000_0000;
		end else begin
			sat32 = v[DATA_W-1:0];
		end
	endfunction

endpackage

`default_nettype wire

// ===== hdl/matrix_palette_vertex_skinning.sv =====
// Matrix palette vertex skinning, Q16.16 linear blend skinning.
// Depends on mpvs_pkg, mpvs_ram and mpvs_ofifo.
//
// The input channel carries two kinds of item. Opcode 0 writes one palette word,
// addressed by bone and word_index, and takes effect for the very next item.
// Opcode 1 carries one influence: a bone and a pre-weighted vector. Influences
// come as bones_per_vertex for the position, then the normal, then the tangent;
// one result leaves on the output channel after the last influence of each.
// The user writes bones_per_vertex on the configuration channel only while the
// block is idle; the block itself does not enforce it.
// The palette sits in one RAM bank per matrix word, all read in the same cycle,
// so one item is taken every clock unless the result queue is full. The last
// influence of a result passes the palette read, twelve parallel multiplies,
// column sums, then the saturating accumulator. Results wait in a two-entry
// queue; in_ready falls only when that queue is full, which stalls the whole
// pipeline until the receiver takes a result.
// Reset clears the counters, sums, pipeline and queue and sets
// bones_per_vertex to 1. Palette contents are undefined until written.
`default_nettype none

module matrix_palette_vertex_skinning #(
	parameter int BONE_COUNT = mpvs_pkg::BONE_COUNT_DEF,
	parameter int BONE_WORDS = mpvs_pkg::BONE_WORDS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic        [mpvs_pkg::BPV_W-1:0]   cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic                                opcode,
	input  wire logic        [mpvs_pkg::BONE_W-1:0]  bone,
	input  wire logic        [mpvs_pkg::WIDX_W-1:0]  word_index,
	input  wire logic signed [mpvs_pkg::DATA_W-1:0]  matrix_word,
	input  wire logic signed [mpvs_pkg::DATA_W-1:0]  vx,
	input  wire logic signed [mpvs_pkg::DATA_W-1:0]  vy,
	input  wire logic signed [mpvs_pkg::DATA_W-1:0]  vz,
	input  wire logic signed [mpvs_pkg::DATA_W-1:0]  vw,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic signed      [mpvs_pkg::DATA_W-1:0]  ox,
	output logic signed      [mpvs_pkg::DATA_W-1:0]  oy,
	output logic signed      [mpvs_pkg::DATA_W-1:0]  oz,
	output logic signed      [mpvs_pkg::DATA_W-1:0]  ow,
	output logic             [mpvs_pkg::ATTR_W-1:0]  attribute
);
	import mpvs_pkg::*;

	localparam int COLS = BONE_WORDS / 4;
	localparam int BA_W = (BONE_COUNT > 1) ? $clog2(BONE_COUNT) : 1;

	// Configuration and sequencing state
	logic [BPV_W-1:0]  bpv_q;
	logic [BPV_W-1:0]  bpv_eff;
	logic [1:0]        infl_cnt_q;
	logic [ATTR_W-1:0] attr_cnt_q;
	logic              inf_last;

	logic              adv;
	logic              in_fire;
	logic              infl_fire;
	logic              pal_we;
	logic              bone_ok;
	logic [BA_W+BONE_W-1:0] bone_ext;
	logic [BA_W-1:0]   bone_addr;
	logic [DATA_W-1:0] pal_rd [BONE_WORDS];

	// Stage 1: palette data arriving from the banks
	logic                     vld_s1;
	logic                     last_s1;
	logic                     pos_s1;
	logic                     ok_s1;
	logic [ATTR_W-1:0]        attr_s1;
	logic signed [DATA_W-1:0] v_s1 [4];

	logic signed [DATA_W-1:0]   mw [3][4];
	logic signed [2*DATA_W-1:0] prod_full [3][4];

	// Stage 2: truncated products
	logic                     vld_s2;
	logic                     last_s2;
	logic [ATTR_W-1:0]        attr_s2;
	logic signed [DATA_W-1:0] vw_s2;
	logic signed [PROD_W-1:0] prod_s2 [3][4];

	logic signed [SUM_W-1:0]  col_sum [3];

	// Stage 3: saturated per-influence column sums
	logic                     vld_s3;
	logic                     last_s3;
	logic [ATTR_W-1:0]        attr_s3;
	logic signed [DATA_W-1:0] vw_s3;
	logic signed [DATA_W-1:0] acc_s3 [3];

	logic signed [DATA_W-1:0] sum_q [3];
	logic signed [DATA_W-1:0] new_sum [3];

	logic push;
	res_t push_data;
	res_t out_data;
	logic fifo_full;

	// Configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpv_q <= BPV_RESET;
		end else if (cfg_valid && cfg_ready) begin
			bpv_q <= cfg_data;
		end
	end

	always_comb begin
		if (bpv_q < BPV_MIN) begin
			bpv_eff = BPV_MIN;
		end else if (bpv_q > BPV_MAX) begin
			bpv_eff = BPV_MAX;
		end else begin
			bpv_eff = bpv_q;
		end
	end

	assign inf_last = ({1'b0, infl_cnt_q} + 3'd1) >= bpv_eff;

	// Input side
	assign adv       = !fifo_full;
	assign in_ready  = adv;
	assign in_fire   = in_valid && in_ready;
	assign infl_fire = in_fire && (opcode == OP_INFLUENCE);
	assign bone_ok   = ({24'd0, bone} < 32'(BONE_COUNT));
	assign pal_we    = in_fire && (opcode == OP_PALETTE) && bone_ok;
	assign bone_ext  = {{BA_W{1'b0}}, bone};
	assign bone_addr = bone_ext[BA_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			infl_cnt_q <= 2'd0;
			attr_cnt_q <= ATTR_POS;
		end else if (infl_fire) begin
			if (inf_last) begin
				infl_cnt_q <= 2'd0;
				attr_cnt_q <= (attr_cnt_q == ATTR_TAN) ? ATTR_POS : attr_cnt_q + 2'd1;
			end else begin
				infl_cnt_q <= infl_cnt_q + 2'd1;
			end
		end
	end

	// One bank per matrix word, so all words of a matrix are read in the same cycle.
	// Word indexes beyond the last bank match no bank and are dropped.
	for (genvar k = 0; k < BONE_WORDS; k++) begin : g_bank
		mpvs_ram #(
			.WIDTH  (DATA_W),
			.DEPTH  (BONE_COUNT),
			.ADDR_W (BA_W)
		) u_bank (
			.clk   (clk),
			.we    (pal_we && (word_index == WIDX_W'(k))),
			.re    (infl_fire),
			.addr  (bone_addr),
			.wdata (matrix_word),
			.rdata (pal_rd[k])
		);
	end

	// Pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= infl_fire;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s1 <= inf_last;
			pos_s1  <= (attr_cnt_q == ATTR_POS);
			ok_s1   <= bone_ok;
			attr_s1 <= attr_cnt_q;
			v_s1[0] <= vx;
			v_s1[1] <= vy;
			v_s1[2] <= vz;
			v_s1[3] <= vw;
		end
	end

	// An out-of-range bone reads as a zero matrix; normal and tangent skip row 3.
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			for (int r = 0; r < 4; r++) begin
				mw[c][r] = (ok_s1 && (r < 3 || pos_s1)) ? $signed(pal_rd[r*COLS + c])
				                                        : '0;
				prod_full[c][r] = mw[c][r] * v_s1[r];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s2 <= last_s1;
			attr_s2 <= attr_s1;
			vw_s2   <= v_s1[3];
			for (int c = 0; c < 3; c++) begin
				for (int r = 0; r < 4; r++) begin
					prod_s2[c][r] <= prod_full[c][r][2*DATA_W-1:DATA_W-PROD_W+DATA_W];
				end
			end
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			col_sum[c] = SUM_W'(prod_s2[c][0]) + SUM_W'(prod_s2[c][1])
			           + SUM_W'(prod_s2[c][2]) + SUM_W'(prod_s2[c][3]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s3 <= last_s2;
			attr_s3 <= attr_s2;
			vw_s3   <= vw_s2;
			for (int c = 0; c < 3; c++) begin
				acc_s3[c] <= sat32(col_sum[c]);
			end
		end
	end

	// Running sums for the current attribute
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			new_sum[c] = sat32(SUM_W'(sum_q[c]) + SUM_W'(acc_s3[c]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < 3; c++) begin
				sum_q[c] <= '0;
			end
		end else if (adv && vld_s3) begin
			for (int c = 0; c < 3; c++) begin
				sum_q[c] <= last_s3 ? '0 : new_sum[c];
			end
		end
	end

	assign push           = adv && vld_s3 && last_s3;
	assign push_data.ox   = new_sum[0];
	assign push_data.oy   = new_sum[1];
	assign push_data.oz   = new_sum[2];
	assign push_data.ow   = (attr_s3 == ATTR_TAN) ? vw_s3 : ONE_Q16;
	assign push_data.attr = attr_s3;

	mpvs_ofifo u_ofifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (fifo_full),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	assign ox        = out_data.ox;
	assign oy        = out_data.oy;
	assign oz        = out_data.oz;
	assign ow        = out_data.ow;
	assign attribute = out_data.attr;

	// The tangent closes the vertex, so the sequencer must return to the position.
	a_vertex_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		infl_fire && inf_last && (attr_cnt_q == ATTR_TAN)
		|=> (attr_cnt_q == ATTR_POS) && (infl_cnt_q == 2'd0))
		else $error("sequencer did not return to position after the tangent");

	// The input is held off only while results are waiting for the receiver.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no result pending");

	a_unit_w: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (attribute != ATTR_TAN) |-> (ow == ONE_Q16))
		else $error("position or normal result without unit w");

endmodule

`default_nettype wire

// ===== hdl/mpvs_ram.sv =====
// Generic single-port RAM with a registered read, one access per cycle.
// Stand-alone; holds one word per address, no reset of the contents.
`default_nettype none

module mpvs_ram #(
	parameter int WIDTH  = 32,
	parameter int DEPTH  = 256,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] addr,
	input  wire logic [WIDTH-1:0]  wdata,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

`default_nettype wire

// ===== hdl/mpvs_ofifo.sv =====
// Two-entry result queue between the accumulator and the output channel.
// Depends on mpvs_pkg for the result record.
`default_nettype none

module mpvs_ofifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire mpvs_pkg::res_t push_data,
	output logic                full,
	output logic                out_valid,
	input  wire logic           out_ready,
	output mpvs_pkg::res_t      out_data
);
	import mpvs_pkg::*;

	res_t       ent_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign full      = (cnt_q == 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = ent_q[rd_q];
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== tb/sv/tb_matrix_palette_vertex_skinning.sv =====
// Self-checking testbench for matrix_palette_vertex_skinning: directed table, then random phases.
// Depends on mpvs_pkg and the block itself. A local Q16.16 model predicts each result
// that no directed row gives; each is checked in order as it leaves the output channel.
`timescale 1ns / 100ps

module tb_matrix_palette_vertex_skinning;

	import mpvs_pkg::*;

	localparam int COLS        = BONE_WORDS_DEF / 4;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYC  = 8;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 46;

	localparam logic signed [DATA_W-1:0] Q_ZERO    = 32'sh0000_0000;
	localparam logic signed [DATA_W-1:0] Q_ONE     = 32'sh0001_0000;
	localparam logic signed [DATA_W-1:0] Q_TWO     = 32'sh0002_0000;
	localparam logic signed [DATA_W-1:0] Q_THREE   = 32'sh0003_0000;
	localparam logic signed [DATA_W-1:0] Q_FOUR    = 32'sh0004_0000;
	localparam logic signed [DATA_W-1:0] Q_EIGHT   = 32'sh0008_0000;
	localparam logic signed [DATA_W-1:0] Q_TWELVE  = 32'sh000C_0000;
	localparam logic signed [DATA_W-1:0] Q_HALF    = 32'sh0000_8000;
	localparam logic signed [DATA_W-1:0] Q_NEG_ONE = 32'shFFFF_0000;
	localparam logic signed [DATA_W-1:0] Q_NEG_TWO = 32'shFFFE_0000;
	localparam logic signed [DATA_W-1:0] Q_MAX     = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] Q_MIN     = 32'sh8000_0000;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;
	typedef enum logic [1:0] {FILL_IDENTITY, FILL_MAX, FILL_RANDOM} mat_fill_e;

	typedef struct packed {
		logic                     op;
		logic [BONE_W-1:0]        bone;
		logic [WIDX_W-1:0]        widx;
		logic signed [DATA_W-1:0] mword;
		logic signed [DATA_W-1:0] vx;
		logic signed [DATA_W-1:0] vy;
		logic signed [DATA_W-1:0] vz;
		logic signed [DATA_W-1:0] vw;
	} skin_item_t;

	typedef struct packed {
		row_kind_e        kind;
		logic [BPV_W-1:0] bpv;
		skin_item_t       item;
		logic             typed;
		res_t             res;
	} dir_row_t;

	logic                     clk;
	logic                     arst_n      = 1'b0;
	logic                     cfg_valid   = 1'b0;
	logic                     cfg_ready;
	logic [BPV_W-1:0]         cfg_data    = '0;
	logic                     in_valid    = 1'b0;
	logic                     in_ready;
	logic                     opcode      = OP_PALETTE;
	logic [BONE_W-1:0]        bone        = '0;
	logic [WIDX_W-1:0]        word_index  = '0;
	logic signed [DATA_W-1:0] matrix_word = '0;
	logic signed [DATA_W-1:0] vx          = '0;
	logic signed [DATA_W-1:0] vy          = '0;
	logic signed [DATA_W-1:0] vz          = '0;
	logic signed [DATA_W-1:0] vw          = '0;
	logic                     out_valid;
	logic                     out_ready   = 1'b0;
	logic signed [DATA_W-1:0] ox;
	logic signed [DATA_W-1:0] oy;
	logic signed [DATA_W-1:0] oz;
	logic signed [DATA_W-1:0] ow;
	logic [ATTR_W-1:0]        attribute;

	// Local copy of the block state, advanced once per accepted transfer.
	logic signed [DATA_W-1:0] palette [BONE_COUNT_DEF][BONE_WORDS_DEF];
	logic [BONE_WORDS_DEF-1:0] words_written [BONE_COUNT_DEF];
	logic [BONE_W-1:0]        loaded_bones [$];
	logic signed [DATA_W-1:0] sum_x, sum_y, sum_z;
	logic [1:0]               infl_count;
	logic [ATTR_W-1:0]        attr_count;
	logic [BPV_W-1:0]         bpv_setting;

	res_t     skinned_due [$];
	dir_row_t directed_rows [$];
	bit       mismatch_seen  = 1'b0;
	int       send_gap_pct   = 0;
	int       recv_stall_pct = 0;
	int       cycle_count    = 0;

	matrix_palette_vertex_skinning dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.bone       (bone),
		.word_index (word_index),
		.matrix_word(matrix_word),
		.vx         (vx),
		.vy         (vy),
		.vz         (vz),
		.vw         (vw),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.ox         (ox),
		.oy         (oy),
		.oz         (oz),
		.ow         (ow),
		.attribute  (attribute)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	function automatic longint clamp_q16(input longint v);
		if (v > longint'(Q_MAX)) return longint'(Q_MAX);
		if (v < longint'(Q_MIN)) return longint'(Q_MIN);
		return v;
	endfunction

	// Mostly values within two units either way, so that sums stay in range, plus extremes and random words.
	function automatic logic signed [DATA_W-1:0] rand_q16();
		case ($urandom_range(0, 15))
			0: begin
				return Q_MAX;
			end
			1: begin
				return Q_MIN;
			end
			2, 3: begin
				return $urandom;
			end
			default: begin
				return $signed($urandom_range(0, 32'h0004_0000)) - Q_TWO;
			end
		endcase
	endfunction

	function automatic void check_field(input string name, input logic [DATA_W-1:0] want,
			input logic [DATA_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %h, actual %h", name, want, got);
			mismatch_seen = 1'b1;
		end
	endfunction

	task automatic skin_transfer(input skin_item_t it, output bit has_res, output res_t r);
		logic signed [DATA_W-1:0] vec [4];
		longint col [3];
		longint col_sum;
		int rows;
		int bpv_eff;
		has_res = 1'b0;
		r = '0;
		if (it.op == OP_PALETTE) begin
			if (it.widx < BONE_WORDS_DEF) begin
				palette[it.bone][it.widx] = it.mword;
				words_written[it.bone][it.widx] = 1'b1;
				if (&words_written[it.bone] && !(it.bone inside {loaded_bones})) begin
					loaded_bones.push_back(it.bone);
				end
			end
			return;
		end
		vec[0] = it.vx;
		vec[1] = it.vy;
		vec[2] = it.vz;
		vec[3] = it.vw;
		// Only the position takes the fourth row.
		rows = (attr_count == ATTR_POS) ? 4 : 3;
		for (int c = 0; c < 3; c++) begin
			col_sum = 0;
			for (int rr = 0; rr < rows; rr++) begin
				col_sum += (longint'(palette[it.bone][rr * COLS + c]) * longint'(vec[rr])) >>> 16;
			end
			col[c] = clamp_q16(col_sum);
		end
		sum_x = 32'(clamp_q16(longint'(sum_x) + col[0]));
		sum_y = 32'(clamp_q16(longint'(sum_y) + col[1]));
		sum_z = 32'(clamp_q16(longint'(sum_z) + col[2]));
		bpv_eff = (bpv_setting < BPV_MIN) ? int'(BPV_MIN) :
			(bpv_setting > BPV_MAX) ? int'(BPV_MAX) : int'(bpv_setting);
		if (int'(infl_count) + 1 < bpv_eff) begin
			infl_count = infl_count + 2'd1;
			return;
		end
		has_res = 1'b1;
		r.ox   = sum_x;
		r.oy   = sum_y;
		r.oz   = sum_z;
		r.ow   = (attr_count == ATTR_TAN) ? it.vw : ONE_Q16;
		r.attr = attr_count;
		sum_x = '0;
		sum_y = '0;
		sum_z = '0;
		infl_count = '0;
		attr_count = (attr_count == ATTR_TAN) ? ATTR_POS : attr_count + 2'd1;
	endtask

	// Called at a rising edge; leaves in_valid high, so the caller either sends again
	// or lowers it before time moves on.
	task automatic send_item(input skin_item_t it, input bit typed, input res_t typed_res);
		bit has_res;
		res_t predicted;
		while ($urandom_range(0, 99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		opcode      <= it.op;
		bone        <= it.bone;
		word_index  <= it.widx;
		matrix_word <= it.mword;
		vx          <= it.vx;
		vy          <= it.vy;
		vz          <= it.vz;
		vw          <= it.vw;
		do @(posedge clk); while (!in_ready);
		skin_transfer(it, has_res, predicted);
		if (has_res) begin
			skinned_due.push_back(typed ? typed_res : predicted);
		end
	endtask

	// Waits for every outstanding result, then lets the pipeline run empty.
	task automatic settle_block();
		in_valid <= 1'b0;
		while (skinned_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_bpv(input logic [BPV_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid   <= 1'b0;
		bpv_setting  = value;
	endtask

	task automatic load_bone(input logic [BONE_W-1:0] b, input mat_fill_e fill);
		int order [BONE_WORDS_DEF];
		int j;
		int tmp;
		int rr;
		int c;
		skin_item_t it;
		foreach (order[i]) order[i] = i;
		for (int i = BONE_WORDS_DEF - 1; i > 0; i--) begin
			j = int'($urandom_range(0, i));
			tmp = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		foreach (order[i]) begin
			rr = order[i] / COLS;
			c  = order[i] % COLS;
			it.op    = OP_PALETTE;
			it.bone  = b;
			it.widx  = WIDX_W'(order[i]);
			it.vx    = $urandom;
			it.vy    = $urandom;
			it.vz    = $urandom;
			it.vw    = $urandom;
			case (fill)
				FILL_MAX: begin
					it.mword = Q_MAX;
				end
				FILL_RANDOM: begin
					it.mword = rand_q16();
				end
				default: begin
					// Identity rotation with a translation of (1, -2, 0.5) in the last row.
					if (rr == 3) begin
						it.mword = (c == 0) ? Q_ONE : (c == 1) ? Q_NEG_TWO : Q_HALF;
					end else begin
						it.mword = (rr == c) ? Q_ONE : Q_ZERO;
					end
				end
			endcase
			send_item(it, 1'b0, '0);
		end
	endtask

	function automatic dir_row_t infl_row(input logic [BONE_W-1:0] b,
			input logic signed [DATA_W-1:0] x, input logic signed [DATA_W-1:0] y,
			input logic signed [DATA_W-1:0] z, input logic signed [DATA_W-1:0] w);
		dir_row_t row;
		row = '0;
		row.kind      = ROW_ITEM;
		row.item.op   = OP_INFLUENCE;
		row.item.bone = b;
		row.item.vx   = x;
		row.item.vy   = y;
		row.item.vz   = z;
		row.item.vw   = w;
		return row;
	endfunction

	function automatic dir_row_t pal_row(input logic [BONE_W-1:0] b, input logic [WIDX_W-1:0] w,
			input logic signed [DATA_W-1:0] value);
		dir_row_t row;
		row = '0;
		row.kind       = ROW_ITEM;
		row.item.op    = OP_PALETTE;
		row.item.bone  = b;
		row.item.widx  = w;
		row.item.mword = value;
		return row;
	endfunction

	function automatic dir_row_t cfg_row(input logic [BPV_W-1:0] value);
		dir_row_t row;
		row = '0;
		row.kind = ROW_CFG;
		row.bpv  = value;
		return row;
	endfunction

	function automatic dir_row_t with_res(input dir_row_t row,
			input logic signed [DATA_W-1:0] x, input logic signed [DATA_W-1:0] y,
			input logic signed [DATA_W-1:0] z, input logic signed [DATA_W-1:0] w,
			input logic [ATTR_W-1:0] a);
		row.typed    = 1'b1;
		row.res.ox   = x;
		row.res.oy   = y;
		row.res.oz   = z;
		row.res.ow   = w;
		row.res.attr = a;
		return row;
	endfunction

	always @(posedge clk) begin : result_check
		res_t due;
		if (arst_n && out_valid && out_ready) begin
			if (skinned_due.size() == 0) begin
				$error("result with none outstanding: attribute %0d, ox %h", attribute, ox);
				mismatch_seen = 1'b1;
			end else begin
				due = skinned_due.pop_front();
				check_field("ox", due.ox, ox);
				check_field("oy", due.oy, oy);
				check_field("oz", due.oz, oz);
				check_field("ow", due.ow, ow);
				check_field("attribute", 32'(due.attr), 32'(attribute));
			end
		end
	end

	initial begin
		skin_item_t it;
		int choice;
		logic [BPV_W-1:0] phase_bpv [PHASES];

		sum_x = '0;
		sum_y = '0;
		sum_z = '0;
		infl_count  = '0;
		attr_count  = ATTR_POS;
		bpv_setting = BPV_RESET;
		foreach (words_written[i]) words_written[i] = '0;
		phase_bpv = '{3'd1, 3'd4, 3'd2, 3'd3, 3'd4, 3'd1, 3'd2, 3'd3};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		load_bone(8'd0, FILL_IDENTITY);
		load_bone(8'd1, FILL_IDENTITY);
		load_bone(8'd255, FILL_MAX);

		// Reset count is one influence per attribute.
		directed_rows.push_back(with_res(infl_row(8'd0, Q_ONE, Q_TWO, Q_THREE, Q_ZERO),
			Q_ONE, Q_TWO, Q_THREE, ONE_Q16, ATTR_POS));
		directed_rows.push_back(with_res(infl_row(8'd0, Q_NEG_ONE, Q_HALF, Q_ZERO, 32'sh1234_5678),
			Q_NEG_ONE, Q_HALF, Q_ZERO, ONE_Q16, ATTR_NRM));
		directed_rows.push_back(with_res(infl_row(8'd0, Q_ZERO, Q_ZERO, Q_ONE, Q_NEG_ONE),
			Q_ZERO, Q_ZERO, Q_ONE, Q_NEG_ONE, ATTR_TAN));
		// Saturation at both ends.
		directed_rows.push_back(with_res(infl_row(8'd255, Q_MAX, Q_MAX, Q_MAX, Q_MAX),
			Q_MAX, Q_MAX, Q_MAX, ONE_Q16, ATTR_POS));
		directed_rows.push_back(with_res(infl_row(8'd255, Q_MIN, Q_MIN, Q_MIN, Q_MIN),
			Q_MIN, Q_MIN, Q_MIN, ONE_Q16, ATTR_NRM));
		// Word indexes past the matrix are dropped and must not land in a neighbour.
		directed_rows.push_back(pal_row(8'd255, 4'd15, Q_ZERO));
		directed_rows.push_back(pal_row(8'd255, 4'd12, Q_ZERO));
		directed_rows.push_back(with_res(infl_row(8'd255, Q_MAX, Q_MAX, Q_MAX, Q_MAX),
			Q_MAX, Q_MAX, Q_MAX, Q_MAX, ATTR_TAN));
		directed_rows.push_back(pal_row(8'd0, 4'd13, Q_MIN));
		directed_rows.push_back(with_res(infl_row(8'd1, Q_ONE, Q_ZERO, Q_ZERO, Q_ONE),
			Q_TWO, Q_NEG_TWO, Q_HALF, ONE_Q16, ATTR_POS));
		// A half in the matrix makes the products round towards minus infinity.
		directed_rows.push_back(pal_row(8'd0, 4'd0, Q_HALF));
		directed_rows.push_back(infl_row(8'd0, 32'shFFFF_FFFF, 32'sh0000_0003, 32'sh8000_0001,
			Q_ZERO));
		directed_rows.push_back(infl_row(8'd0, 32'sh0000_0001, 32'shFFFF_FFFD, Q_HALF, Q_MIN));
		directed_rows.push_back(cfg_row(BPV_MAX));
		repeat (3) directed_rows.push_back(infl_row(8'd1, Q_ONE, Q_TWO, Q_THREE, Q_ZERO));
		directed_rows.push_back(with_res(infl_row(8'd1, Q_ONE, Q_TWO, Q_THREE, Q_ZERO),
			Q_FOUR, Q_EIGHT, Q_TWELVE, ONE_Q16, ATTR_POS));
		// Two normal influences in, then the count drops, so the next one closes the normal.
		directed_rows.push_back(infl_row(8'd255, Q_HALF, Q_NEG_ONE, 32'sh0000_0100, Q_ZERO));
		directed_rows.push_back(infl_row(8'd255, Q_NEG_ONE, Q_HALF, 32'shFFFF_FF00, Q_ZERO));
		directed_rows.push_back(cfg_row(3'd0));
		directed_rows.push_back(infl_row(8'd1, Q_HALF, Q_HALF, Q_NEG_ONE, Q_ONE));
		directed_rows.push_back(cfg_row(3'd7));
		directed_rows.push_back(infl_row(8'd1, Q_ONE, Q_NEG_TWO, Q_HALF, Q_ONE));
		directed_rows.push_back(infl_row(8'd0, Q_MAX, Q_ZERO, Q_MIN, Q_NEG_ONE));
		directed_rows.push_back(infl_row(8'd0, Q_HALF, Q_THREE, Q_NEG_ONE, Q_ONE));
		directed_rows.push_back(infl_row(8'd1, Q_NEG_TWO, Q_ONE, Q_HALF, Q_NEG_ONE));

		send_gap_pct   = 22;
		recv_stall_pct = 22;
		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CFG) begin
				settle_block();
				write_bpv(directed_rows[i].bpv);
			end else begin
				send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].res);
			end
		end

		send_gap_pct   = 0;
		recv_stall_pct = 0;
		repeat (6) load_bone(BONE_W'($urandom_range(2, 254)), FILL_RANDOM);

		for (int ph = 0; ph < PHASES; ph++) begin
			settle_block();
			write_bpv(phase_bpv[ph]);
			case (ph % 4)
				0: begin
					send_gap_pct   = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_gap_pct   = 73;
					recv_stall_pct = 0;
				end
				2: begin
					send_gap_pct   = 0;
					recv_stall_pct = 73;
				end
				default: begin
					send_gap_pct   = 22;
					recv_stall_pct = 22;
				end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// Now and then hold the input back until the output has caught up.
				if ($urandom_range(0, 49) == 0 || (ph == 3 && n == PHASE_ITEMS / 2)) begin
					settle_block();
				end
				choice = int'($urandom_range(0, 99));
				it.vx    = rand_q16();
				it.vy    = rand_q16();
				it.vz    = rand_q16();
				it.vw    = rand_q16();
				it.mword = rand_q16();
				if (choice < 12) begin
					it.op   = OP_PALETTE;
					it.widx = WIDX_W'($urandom_range(0, 15));
					if (choice < 6) begin
						it.bone = loaded_bones[$urandom_range(0, loaded_bones.size() - 1)];
					end else begin
						it.bone = BONE_W'($urandom_range(0, 255));
					end
				end else begin
					it.op   = OP_INFLUENCE;
					it.widx = WIDX_W'($urandom_range(0, 15));
					it.bone = loaded_bones[$urandom_range(0, loaded_bones.size() - 1)];
				end
				send_item(it, 1'b0, '0);
			end
		end

		settle_block();
		if (!mismatch_seen && skinned_due.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/mpvs_pkg.sv
hdl/mpvs_ram.sv
hdl/mpvs_ofifo.sv
hdl/matrix_palette_vertex_skinning.sv
tb/sv/tb_matrix_palette_vertex_skinning.sv
